/* rtl/fsw_pkg.sv */
// Shared constants and types of the first-subarray-sum window unit.
package fsw_pkg;

  localparam int MAX_LEN_DEF   = 1024;
  localparam int ELEM_BITS_DEF = 16;
  localparam int TARGET_W      = 26;
  localparam int IDX_OUT_W     = 10;
  localparam int STATUS_W      = 2;
  localparam int M_DATA_W      = ((2 * IDX_OUT_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT
  } state_e;

endpackage

/* rtl/fsw_store.sv */
// Element memory with registered synchronous read and write-to-read forwarding.
module fsw_store #(
  parameter int DEPTH  = fsw_pkg::MAX_LEN_DEF,
  parameter int DATA_W = fsw_pkg::ELEM_BITS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q    <= mem[raddr_i];
    fwd_data_q <= wdata_i;
  end

  // the array reads old data on a same-address collision: remember the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

/* rtl/first_subarray_sum_window_unit.sv */
// Top level of the first-subarray-sum sliding window unit.
//
// Input stream: s_axis carries one array element per transaction in tdata, with
// tlast on the final element of an array. Output stream: m_axis carries at
// most one result per array: status in tuser, first and last window index in
// tdata (zero unless found). The user must write the target sum through cfg_we_i /
// cfg_wdata_i while the unit is idle (unchecked); used from the next element.
//
// An element is checked in the cycle after it is taken; each element dropped
// from the window front holds the unit in the check state, since every drop
// reads the element memory once through its single read port. A result waits
// in the pending registers until the emit state loads it into the output
// register that drives m_axis.
//
// Reset clears the window, the element count and the output valid, and sets
// the target to 1; the element memory is not cleared, only entries written
// in the current array are read. When the receiver stalls, the result waits
// in the output register while the next element is still taken; a second
// result then holds the unit until the first one leaves.
module first_subarray_sum_window_unit #(
  parameter int MAX_LEN   = fsw_pkg::MAX_LEN_DEF,
  parameter int ELEM_BITS = fsw_pkg::ELEM_BITS_DEF,
  parameter int S_DATA_W  = ((ELEM_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg: target_sum
  input  logic                          cfg_we_i,
  input  logic [fsw_pkg::TARGET_W-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [S_DATA_W-1:0]           s_axis_tdata,  // element_value
  input  logic                          s_axis_tlast,  // array_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fsw_pkg::M_DATA_W-1:0]  m_axis_tdata,  // first_index, last_index
  output logic [fsw_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);

  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int TGT_W     = fsw_pkg::TARGET_W;
  localparam int SUM_W     = ((ELEM_BITS > TGT_W) ? ELEM_BITS : TGT_W) + 1;
  localparam int OUT_IDX_W = fsw_pkg::IDX_OUT_W;
  localparam int M_DATA_W  = fsw_pkg::M_DATA_W;

  fsw_pkg::state_e state_q, state_d;

  logic [TGT_W-1:0]     target_q;
  logic [CNT_W-1:0]     front_q, front_d;
  logic [CNT_W-1:0]     items_q, items_d;
  logic [SUM_W-1:0]     total_q, total_d;
  logic                 answered_q, answered_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;

  fsw_pkg::status_e     pend_status_q, pend_status_d;
  logic [OUT_IDX_W-1:0] pend_first_q, pend_first_d;
  logic [OUT_IDX_W-1:0] pend_last_q, pend_last_d;
  fsw_pkg::status_e     out_status_q;
  logic [OUT_IDX_W-1:0] out_first_q, out_last_q;

  logic                 in_fire;
  logic                 slot_free;
  logic                 full;
  logic                 mem_we;
  logic [ELEM_BITS-1:0] elem;
  logic [ELEM_BITS-1:0] front_elem;
  logic                 win_nonempty;
  logic                 shrink;
  logic                 found;

  assign elem         = s_axis_tdata[ELEM_BITS-1:0];
  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign slot_free    = !out_valid_q || m_axis_tready;
  assign full         = (items_q == CNT_W'(MAX_LEN));
  assign mem_we       = in_fire && !answered_q && !full;
  assign win_nonempty = (front_q < items_q);
  assign shrink       = (total_q > SUM_W'(target_q)) && win_nonempty;
  assign found        = win_nonempty && (total_q == SUM_W'(target_q));

  fsw_store #(
    .DEPTH  (MAX_LEN),
    .DATA_W (ELEM_BITS),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (items_q[IDX_W-1:0]),
    .wdata_i (elem),
    .raddr_i (front_d[IDX_W-1:0]),
    .rdata_o (front_elem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsw_pkg::S_IDLE: begin
        if (in_fire && !answered_q) begin
          state_d = full ? fsw_pkg::S_EMIT : fsw_pkg::S_CHECK;
        end
      end
      fsw_pkg::S_CHECK: begin
        if (!shrink) begin
          state_d = (found || last_q) ? fsw_pkg::S_EMIT : fsw_pkg::S_IDLE;
        end
      end
      fsw_pkg::S_EMIT: begin
        if (slot_free) begin
          state_d = fsw_pkg::S_IDLE;
        end
      end
      default: state_d = fsw_pkg::S_IDLE;
    endcase
  end

  // window datapath
  always_comb begin
    front_d       = front_q;
    items_d       = items_q;
    total_d       = total_q;
    answered_d    = answered_q;
    last_d        = last_q;
    pend_status_d = pend_status_q;
    pend_first_d  = pend_first_q;
    pend_last_d   = pend_last_q;
    unique case (state_q)
      fsw_pkg::S_IDLE: begin
        if (in_fire) begin
          last_d = s_axis_tlast;
          priority if (answered_q) begin
            if (s_axis_tlast) begin
              front_d    = '0;
              items_d    = '0;
              total_d    = '0;
              answered_d = 1'b0;
            end
          end else if (full) begin
            pend_status_d = fsw_pkg::ST_TOO_LONG;
            pend_first_d  = '0;
            pend_last_d   = '0;
            answered_d    = !s_axis_tlast;
            if (s_axis_tlast) begin
              front_d = '0;
              items_d = '0;
              total_d = '0;
            end
          end else begin
            items_d = items_q + 1'b1;
            total_d = total_q + SUM_W'(elem);
          end
        end
      end
      fsw_pkg::S_CHECK: begin
        if (shrink) begin
          // drop the front element; its successor is read this cycle
          total_d = total_q - SUM_W'(front_elem);
          front_d = front_q + 1'b1;
        end else begin
          if (found) begin
            pend_status_d = fsw_pkg::ST_FOUND;
            pend_first_d  = OUT_IDX_W'(front_q);
            pend_last_d   = OUT_IDX_W'(items_q - 1'b1);
            answered_d    = 1'b1;
          end else begin
            pend_status_d = fsw_pkg::ST_NOT_FOUND;
            pend_first_d  = '0;
            pend_last_d   = '0;
          end
          if (last_q) begin
            front_d    = '0;
            items_d    = '0;
            total_d    = '0;
            answered_d = 1'b0;
          end
        end
      end
      fsw_pkg::S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == fsw_pkg::S_EMIT) && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  assign s_axis_tready = (state_q == fsw_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = M_DATA_W'({out_last_q, out_first_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsw_pkg::S_IDLE;
      target_q    <= TGT_W'(1);
      front_q     <= '0;
      items_q     <= '0;
      total_q     <= '0;
      answered_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      items_q     <= items_d;
      total_q     <= total_d;
      answered_q  <= answered_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q        <= last_d;
    pend_status_q <= pend_status_d;
    pend_first_q  <= pend_first_d;
    pend_last_q   <= pend_last_d;
    if ((state_q == fsw_pkg::S_EMIT) && slot_free) begin
      out_status_q <= pend_status_q;
      out_first_q  <= pend_first_q;
      out_last_q   <= pend_last_q;
    end
  end

endmodule

/* rtl/fsw_checker.sv */
// Port-level checks of the first-subarray-sum window unit, bound to the top level.
module fsw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fsw_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic [fsw_pkg::STATUS_W-1:0]  m_axis_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == fsw_pkg::ST_FOUND ||
                       m_axis_tuser == fsw_pkg::ST_NOT_FOUND ||
                       m_axis_tuser == fsw_pkg::ST_TOO_LONG))
    else $error("undefined status code");

  // drop indices unless a window matched
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != fsw_pkg::ST_FOUND) |-> (m_axis_tdata == '0))
    else $error("nonzero indices on a miss");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result shown during reset");

endmodule

bind first_subarray_sum_window_unit fsw_checker u_fsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
